>>> hdl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types and constants for the dead-reckoning odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int ATAN_ENTRIES = 30;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam logic [15:0] DIST_RESET   = 16'd5090;
    localparam logic [23:0] TURN_RESET   = 24'd1784600;
    localparam logic [0:0]  CFG_DIST     = 1'b0;
    localparam logic [0:0]  CFG_TURN     = 1'b1;

    // datapath widths
    localparam int DW = 34;   // count sums / differences, signed
    localparam int AW = 48;   // multiplicand, signed (half travel product)
    localparam int PW = 64;   // products, signed
    localparam int CW = 56;   // CORDIC x/y, signed

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_ROT, ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic [AW-1:0] a;
        logic [23:0] b;
    } mul_req_t;

    function automatic logic [31:0] atan_ba(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E;
                5'd2: r = 32'h09FB385B; 5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53; 5'd9: r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> hdl/ddo_serial_mul.sv
// ----------------------------------------------------------------------------
// ddo_serial_mul
// Bit-serial signed x unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_serial_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ddo_pkg::mul_req_t     req,
    output logic                  done,
    output logic [ddo_pkg::PW-1:0] prod
);
    import ddo_pkg::*;

    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [23:0]   mplier_reg, mplier_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            acc_next    = '0;
            mcand_next  = {{(PW-AW){req.a[AW-1]}}, req.a};
            mplier_next = req.b;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

>>> hdl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with
// quadrant folding.
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int STEPS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [ddo_pkg::CW-1:0] mag,
    input  logic [31:0]            ang,
    output logic                   done,
    output logic [ddo_pkg::CW-1:0] cx,
    output logic [ddo_pkg::CW-1:0] cy
);
    import ddo_pkg::*;

    localparam int NSTEP = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [32:0]   z_reg, z_next;
    logic [4:0]           i_reg, i_next;
    logic                 flip_reg, flip_next;
    logic                 busy_reg, busy_next, done_reg, done_next;
    logic signed [CW-1:0] xs, ys;
    logic [31:0]          a_fold;

    always_comb
    begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        i_next = i_reg; flip_next = flip_reg;
        busy_next = busy_reg; done_next = 1'b0;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        a_fold = ang;
        if (start)
        begin
            flip_next = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
            if (flip_next)
                a_fold = ang - HALF_TURN;
            x_next = mag;
            y_next = '0;
            z_next = {a_fold[31], a_fold};
            i_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - $signed({1'b0, atan_ba(i_reg)});
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + $signed({1'b0, atan_ba(i_reg)});
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(NSTEP - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign done = done_reg;
    assign cx = flip_reg ? -x_reg : x_reg;
    assign cy = flip_reg ? -y_reg : y_reg;
endmodule

>>> hdl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning pose tracker for a two-wheel differential drive.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (valid/ready): action, left_count, right_count. An item
//    with action 1 zeroes the pose, faces a quarter turn and latches the
//    counts as baseline; action 0 integrates the count deltas.
//  - Output channel (valid/ready): pos_x, pos_y, heading after the item.
//  - Config port: cfg_we/cfg_index/cfg_data; the user must write it only while idle, the block does not enforce this.
//  - An update item runs three bit-serial multiplies (turn product, travel
//    product, inverse-gain scaling), then the CORDIC rotation, one step per
//    cycle. A reset item's result is valid the next cycle. One item is in
//    flight at a time.
//  - The result sits in the output register until taken; a stalled receiver
//    simply holds the block in its done state, new items wait.
//  - Reset: pose at origin, heading a quarter turn, baseline counts zero,
//    registers at their defaults.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] left_count,
    input  logic [31:0] right_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] heading,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import ddo_pkg::*;

    state_t state_reg, state_next;
    logic [15:0] dist_reg;
    logic [23:0] turn_reg;
    logic [31:0] prev_l_reg, prev_r_reg, ang_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [DW-1:0] sum_reg, diff_reg;
    logic [PW-1:0] p_reg;
    logic [1:0]    phase_reg;   // 0 turn, 1 travel, 2 gain, 3 turn running
    logic signed [PW-1:0] half_d;
    logic [31:0] mid_ang;

    mul_req_t mreq;
    logic     mdone;
    logic [PW-1:0] mprod;
    logic     cstart, cdone;
    logic [CW-1:0] cx, cy, cmag;

    // half travel product, held for the gain multiply
    logic signed [AW-1:0] hd_reg;

    ddo_serial_mul u_mul (.clk, .rst_n, .req(mreq), .done(mdone), .prod(mprod));
    ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk, .rst_n, .start(cstart), .mag(cmag), .ang(mid_ang),
        .done(cdone), .cx, .cy);

    assign half_d  = $signed(mprod) >>> 1;
    assign mid_ang = ang_reg + p_reg[32:1];

    function automatic logic signed [31:0] sat(input logic signed [31:0] a,
                                              input logic signed [CW-1:0] d);
        logic signed [CW:0] r;
        begin
            r = {{(CW-31){a[31]}}, a} + {d[CW-1], d};
            if (r > $signed({{(CW-31){1'b0}}, 32'h7FFF_FFFF}))
                return 32'sh7FFF_FFFF;
            else if (r < -$signed({{(CW-31){1'b0}}, 32'h8000_0000}))
                return 32'sh8000_0000;
            else
                return r[31:0];
        end
    endfunction

    always_comb
    begin
        state_next = state_reg;
        mreq = '0;
        cstart = 1'b0;
        cmag = '0;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && !action)
                    state_next = ST_MUL1;
                else if (in_valid)
                    state_next = ST_DONE;
            ST_MUL1:
                begin
                    mreq.start = (phase_reg == 2'd0);
                    mreq.a = {{(AW-DW){diff_reg[DW-1]}}, diff_reg};
                    mreq.b = turn_reg;
                    if (mdone)
                        state_next = ST_MUL2;
                end
            ST_MUL2:
                begin
                    mreq.start = (phase_reg == 2'd0);
                    mreq.a = {{(AW-DW){sum_reg[DW-1]}}, sum_reg};
                    mreq.b = {8'd0, dist_reg};
                    if (phase_reg == 2'd1 && mdone)
                        state_next = ST_ROT;
                end
            ST_ROT:
                begin
                    mreq.start = (phase_reg == 2'd1);
                    mreq.a = hd_reg;
                    mreq.b = {8'd0, INV_GAIN_Q16};
                    cstart = (phase_reg == 2'd2) && mdone;
                    cmag = CW'($signed(mprod) >>> 16);
                    if (cdone)
                        state_next = ST_DONE;
                end
            ST_DONE:
                if (out_ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= 2'd0;
            dist_reg   <= DIST_RESET;
            turn_reg   <= TURN_RESET;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            ang_reg    <= QUARTER_TURN;
            x_reg      <= '0;
            y_reg      <= '0;
            p_reg      <= '0;
            hd_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DIST: dist_reg <= cfg_data[15:0];
                    CFG_TURN: turn_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                    if (in_valid)
                    begin
                        phase_reg <= 2'd0;
                        if (action)
                        begin
                            ang_reg <= QUARTER_TURN;
                            x_reg <= '0;
                            y_reg <= '0;
                        end
                        prev_l_reg <= left_count;
                        prev_r_reg <= right_count;
                    end
                ST_MUL1:
                    if (phase_reg == 2'd0)
                        phase_reg <= 2'd3;
                    else if (mdone)
                    begin
                        p_reg <= mprod;
                        phase_reg <= 2'd0;
                    end
                ST_MUL2:
                    if (phase_reg == 2'd0)
                        phase_reg <= 2'd1;
                    else if (mdone)
                        hd_reg <= half_d[AW-1:0];
                ST_ROT:
                    if (phase_reg == 2'd1)
                        phase_reg <= 2'd2;
                    else if (cdone)
                    begin
                        x_reg <= sat(x_reg, cx);
                        y_reg <= sat(y_reg, cy);
                        ang_reg <= ang_reg + p_reg[31:0];
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            sum_reg  <= $signed({{2{1'b0}}, 32'd0})
                      + $signed({{2{1'(32'(left_count - prev_l_reg) >> 31)}},
                                 32'(left_count - prev_l_reg)})
                      + $signed({{2{1'(32'(right_count - prev_r_reg) >> 31)}},
                                 32'(right_count - prev_r_reg)});
            diff_reg <= $signed({{2{1'(32'(left_count - prev_l_reg) >> 31)}},
                                 32'(left_count - prev_l_reg)})
                      - $signed({{2{1'(32'(right_count - prev_r_reg) >> 31)}},
                                 32'(right_count - prev_r_reg)});
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign pos_x     = x_reg;
    assign pos_y     = y_reg;
    assign heading   = ang_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heading))
        else $error("result dropped while stalled");
    a_reset_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action |=> out_valid && heading == QUARTER_TURN)
        else $error("reset item did not restore heading");
`endif
endmodule
